// File: design/assert_macros.svh
// Assertion macros for the table's RTL; only the back end uses them.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define LPTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define LPTT_NEVER(lbl, cond, msg) \
  `LPTT_ASSERT(lbl, !(cond), msg)

`endif

// File: design/lptt_pkg.sv
// Shared types and codes for the linear-probe tag table.
// No dependencies; used by every module of the block but lptt_ram.
package lptt_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int HOME_W          = 16;
  localparam int OUT_SLOT_W      = 10;
  localparam int OCC_W           = 11;
  localparam int TSIZE_W         = 11;
  localparam int ADDR_W          = 48;
  localparam int TAG_W           = 32;
  localparam int PSIZE_W         = 32;
  localparam int HASH_W          = 64;
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 64;
  localparam logic [ADDR_W-1:0] HEADER_BYTES = 48'd20;

  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_UPSERT = 2'd2;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPSERT = 2'd2;
  localparam logic [1:0] OP_BADTAG = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EXISTS    = 3'd3;
  localparam logic [2:0] ST_IN_PLACE  = 3'd4;
  localparam logic [2:0] ST_RELOCATED = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;
  localparam logic [2:0] ST_BAD_TAG   = 3'd7;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ADDR_W-1:0]  pos;
    logic [PSIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [TAG_W-1:0]   tag;
    logic [PSIZE_W-1:0] size;
    logic [HOME_W-1:0]  home;
  } item_t;

endpackage

// File: design/lptt_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module lptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lptt_fifo.sv
// Two-entry transaction queue between the front and back ends.
// Depends on lptt_pkg for the queued item type.
module lptt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lptt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lptt_pkg::item_t pop_item,
  output logic            not_empty
);
  import lptt_pkg::*;

  item_t      mem_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_item  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// File: design/lptt_front.sv
// Front end: accepts transactions, classifies them and finds the home slot.
// Depends on lptt_pkg; the home slot is found four quotient bits per cycle.
module lptt_front #(
  parameter int TABLE_DEPTH = lptt_pkg::DEF_TABLE_DEPTH,
  parameter int SIZE_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  logic [SIZE_W-1:0]             n_i,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [lptt_pkg::HASH_W-1:0]   in_index_hash,
  input  logic [lptt_pkg::TAG_W-1:0]    in_tag,
  input  logic [lptt_pkg::PSIZE_W-1:0]  in_payload_size,
  output logic                          q_push,
  output lptt_pkg::item_t               q_item,
  input  logic                          q_full
);
  import lptt_pkg::*;

  localparam int DIGIT    = 4;
  localparam int STEPS    = HASH_W / DIGIT;
  localparam int STEP_W   = $clog2(STEPS);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PSIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] rem_step;

  always_comb begin
    logic [SIZE_W:0] t;
    t = {1'b0, rem_r};
    for (int k = 0; k < DIGIT; k++) begin
      t = {t[SIZE_W-1:0], hash_r[HASH_W-1-k]};
      if (t >= {1'b0, n_i}) begin
        t = t - {1'b0, n_i};
      end
    end
    rem_step = t[SIZE_W-1:0];
  end

  assign in_ready = enable && (state_r == S_IDLE);
  assign q_push   = (state_r == S_PUSH) && !q_full;
  assign q_item   = '{op: op_r, tag: tag_r, size: size_r, home: HOME_W'(rem_r)};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    hash_nxt  = hash_r;
    rem_nxt   = rem_r;
    op_nxt    = op_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          hash_nxt  = in_index_hash;
          rem_nxt   = '0;
          step_nxt  = '0;
          tag_nxt   = in_tag;
          size_nxt  = in_payload_size;
          if (in_tag == '0) begin
            op_nxt = OP_BADTAG;
          end else if (in_mode == MODE_INSERT) begin
            op_nxt = OP_INSERT;
          end else if (in_mode == MODE_UPSERT) begin
            op_nxt = OP_UPSERT;
          end else begin
            op_nxt = OP_LOOKUP;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_step;
        hash_nxt = hash_r << DIGIT;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    rem_r  <= rem_nxt;
    op_r   <= op_nxt;
    tag_r  <= tag_nxt;
    size_r <= size_nxt;
  end

endmodule

// File: design/lptt_back.sv
// Back end: clears the slot memory, walks the probe sequence and updates entries.
// Depends on lptt_pkg, lptt_ram and assert_macros.svh.
`include "assert_macros.svh"
module lptt_back #(
  parameter int TABLE_DEPTH = lptt_pkg::DEF_TABLE_DEPTH,
  parameter int SIZE_W      = $clog2(TABLE_DEPTH + 1),
  parameter int SLOT_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [SIZE_W-1:0]                n_i,
  input  logic [lptt_pkg::ADDR_W-1:0]      data_start_i,
  output logic                             clear_done,
  input  logic                             q_not_empty,
  input  lptt_pkg::item_t                  q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [lptt_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic [lptt_pkg::ADDR_W-1:0]      out_position,
  output logic [lptt_pkg::PSIZE_W-1:0]     out_record_size,
  output logic [lptt_pkg::OCC_W-1:0]       out_occupied
);
  import lptt_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_r, clr_nxt;
  logic [SLOT_W-1:0]  probe_r, probe_nxt;
  logic [SIZE_W-1:0]  cnt_r, cnt_nxt;
  item_t              item_r, item_nxt;
  logic [ADDR_W-1:0]  newpos_r, newpos_nxt;
  logic [ADDR_W-1:0]  nextapp_r, nextapp_nxt;
  logic [ADDR_W-1:0]  append_r, append_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [2:0]         res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [ADDR_W-1:0]  res_pos_r, res_pos_nxt;
  logic [PSIZE_W-1:0] res_size_r, res_size_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [ADDR_W-1:0]  out_pos_r;
  logic [PSIZE_W-1:0] out_size_r;
  logic [OCC_W-1:0]   out_occ_r;
  logic               load_out;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr;
  entry_t             ram_wdata, ent;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic               is_empty, is_hit, is_last;
  logic [SIZE_W-1:0]  probe_inc;

  lptt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(probe_r),
    .rdata(ram_rdata)
  );

  assign ent        = entry_t'(ram_rdata);
  assign is_empty   = ent.tag == '0;
  assign is_hit     = ent.tag == item_r.tag;
  assign is_last    = (cnt_r + SIZE_W'(1)) == n_i;
  assign probe_inc  = SIZE_W'(probe_r) + SIZE_W'(1);
  assign ram_re     = state_r == S_PROBE;
  assign clear_done = state_r != S_CLEAR;
  assign q_pop      = (state_r == S_IDLE) && q_not_empty;
  assign load_out   = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_position    = out_pos_r;
  assign out_record_size = out_size_r;
  assign out_occupied    = out_occ_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    probe_nxt      = probe_r;
    cnt_nxt        = cnt_r;
    item_nxt       = item_r;
    newpos_nxt     = newpos_r;
    nextapp_nxt    = nextapp_r;
    append_nxt     = append_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_pos_nxt    = res_pos_r;
    res_size_nxt   = res_size_r;
    ram_we         = 1'b0;
    ram_waddr      = probe_r;
    ram_wdata      = '{tag: item_r.tag, pos: newpos_r, size: item_r.size};
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          item_nxt    = q_item;
          probe_nxt   = SLOT_W'(q_item.home);
          cnt_nxt     = '0;
          newpos_nxt  = data_start_i + append_r;
          nextapp_nxt = append_r + HEADER_BYTES + ADDR_W'(q_item.size);
          if (q_item.op == OP_BADTAG) begin
            res_status_nxt = ST_BAD_TAG;
            res_slot_nxt   = '0;
            res_pos_nxt    = '0;
            res_size_nxt   = '0;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        res_slot_nxt = probe_r;
        res_pos_nxt  = '0;
        res_size_nxt = '0;
        state_nxt    = S_RESULT;
        if (!is_empty && !is_hit && !is_last) begin
          cnt_nxt   = cnt_r + SIZE_W'(1);
          probe_nxt = (probe_inc == n_i) ? '0 : SLOT_W'(probe_inc);
          state_nxt = S_PROBE;
        end else if (is_hit && (item_r.op == OP_LOOKUP || item_r.op == OP_INSERT)) begin
          res_status_nxt = (item_r.op == OP_LOOKUP) ? ST_FOUND : ST_EXISTS;
          res_pos_nxt    = ent.pos;
          res_size_nxt   = ent.size;
        end else if (is_hit) begin
          ram_we       = 1'b1;
          res_size_nxt = item_r.size;
          if (item_r.size <= ent.size) begin
            res_status_nxt = ST_IN_PLACE;
            ram_wdata.pos  = ent.pos;
            res_pos_nxt    = ent.pos;
          end else begin
            res_status_nxt = ST_RELOCATED;
            res_pos_nxt    = newpos_r;
            append_nxt     = nextapp_r;
          end
        end else if (is_empty && item_r.op != OP_LOOKUP) begin
          ram_we         = 1'b1;
          res_status_nxt = ST_INSERTED;
          res_pos_nxt    = newpos_r;
          res_size_nxt   = item_r.size;
          append_nxt     = nextapp_r;
          occ_nxt        = occ_r + OCC_W'(1);
        end else begin
          res_status_nxt = (item_r.op == OP_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
          res_slot_nxt   = '0;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      append_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      append_r    <= append_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    cnt_r        <= cnt_nxt;
    item_r       <= item_nxt;
    newpos_r     <= newpos_nxt;
    nextapp_r    <= nextapp_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pos_r    <= res_pos_nxt;
    res_size_r   <= res_size_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= OUT_SLOT_W'(res_slot_r);
      out_pos_r    <= res_pos_r;
      out_size_r   <= res_size_r;
      out_occ_r    <= occ_r;
    end
  end

  `LPTT_ASSERT(a_we_phase, ram_we |-> (state_r == S_CLEAR || state_r == S_CHECK),
    "slot memory written outside clearing or entry update")
  `LPTT_ASSERT(a_probe_range, state_r == S_PROBE |-> (SIZE_W'(probe_r) < n_i && cnt_r < n_i),
    "probe walked beyond the table size")
  `LPTT_NEVER(a_pop_clear, q_pop && !$past(clear_done),
    "transaction taken before the clearing pass finished")

endmodule

// File: design/linear_probe_tag_table.sv
// Linear-probe tag table: open-addressing hash table with linear probing.
// Input transactions (in_*) carry mode, index hash, tag and payload size; every
// one yields exactly one result transaction (out_*) with valid/ready handshakes.
// The APB-style cfg_* port holds table_size at byte address 0 and data_start at
// byte address 8; write it only while the table is idle.
// A front end accepts a transaction and works out the home slot, four quotient
// bits a cycle; a two-entry queue then hands it to the back end, and the front
// end takes a new transaction only once it has pushed the last one to the queue.
// The back end takes the transaction from the queue, then probes each slot by
// reading the registered slot memory (S_PROBE) and checking the entry (S_CHECK),
// and at last loads the output register; a zero tag skips the probing.
// After reset the back end clears the slot memory, one slot a cycle; in_ready
// stays low until the clearing is done, configuration is still taken.
// When the receiver stalls, the result waits in the output register while the
// back end, the queue and the front end go on taking up to four further
// transactions.
module linear_probe_tag_table #(
  parameter int TABLE_DEPTH = lptt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [lptt_pkg::HASH_W-1:0]     in_index_hash,
  input  logic [lptt_pkg::TAG_W-1:0]      in_tag,
  input  logic [lptt_pkg::PSIZE_W-1:0]    in_payload_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [lptt_pkg::OUT_SLOT_W-1:0] out_slot,
  output logic [lptt_pkg::ADDR_W-1:0]     out_position,
  output logic [lptt_pkg::PSIZE_W-1:0]    out_record_size,
  output logic [lptt_pkg::OCC_W-1:0]      out_occupied,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lptt_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [lptt_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [lptt_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import lptt_pkg::*;

  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (SIZE_W > TSIZE_W) ? SIZE_W : TSIZE_W;

  logic [TSIZE_W-1:0] table_size_r, table_size_nxt;
  logic [ADDR_W-1:0]  data_start_r, data_start_nxt;
  logic               cfg_wr;
  logic [SIZE_W-1:0]  n_eff;
  logic               clear_done;
  logic               q_push, q_full, q_pop, q_not_empty;
  item_t              q_in, q_out;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[3] ? CFG_DW'(data_start_r) : CFG_DW'(table_size_r);

  always_comb begin
    table_size_nxt = table_size_r;
    data_start_nxt = data_start_r;
    if (cfg_wr) begin
      if (cfg_paddr[3]) begin
        data_start_nxt = cfg_pwdata[ADDR_W-1:0];
      end else begin
        table_size_nxt = cfg_pwdata[TSIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TSIZE_W'(1024);
      data_start_r <= '0;
    end else begin
      table_size_r <= table_size_nxt;
      data_start_r <= data_start_nxt;
    end
  end

  always_comb begin
    if (table_size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (CMP_W'(table_size_r) > CMP_W'(TABLE_DEPTH)) begin
      n_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_eff = SIZE_W'(table_size_r);
    end
  end

  lptt_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .enable         (clear_done),
    .n_i            (n_eff),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_index_hash  (in_index_hash),
    .in_tag         (in_tag),
    .in_payload_size(in_payload_size),
    .q_push         (q_push),
    .q_item         (q_in),
    .q_full         (q_full)
  );

  lptt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_item (q_out),
    .not_empty(q_not_empty)
  );

  lptt_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .n_i            (n_eff),
    .data_start_i   (data_start_r),
    .clear_done     (clear_done),
    .q_not_empty    (q_not_empty),
    .q_item         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_position   (out_position),
    .out_record_size(out_record_size),
    .out_occupied   (out_occupied)
  );

endmodule
